// ===== hw/rtl/bbvrpc_pkg.sv =====
`timescale 1ns / 1ps

package bbvrpc_pkg;

   // Request command codes.
   localparam logic [1:0] CMD_COUNT = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_DUMP  = 2'd2;

   // drand48 generator: multiplier split into its low 32 bits and high 3 bits.
   localparam logic [31:0] LCG_MUL_LO = 32'hDEEC_E66D;
   localparam logic [2:0]  LCG_MUL_HI = 3'h5;
   localparam logic [47:0] LCG_ADD    = 48'hB;
   localparam logic [15:0] SEED_LOW   = 16'h330E;

   localparam int NUM_STREAMS  = 4;
   localparam int DIM_INDEX_W  = 4;
   localparam int ACC_W        = 64;
   localparam int COUNT_W      = 32;
   localparam int ADDR_W       = 64;
   localparam int LCG_W        = 48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CNT_LO,
      ST_CNT_HI,
      ST_CNT_W,
      ST_CNT_ACC,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } state_type;

endpackage

// ===== hw/rtl/bbv_random_projection_counter_unit.sv =====
`timescale 1ns / 1ps
// Count request: one shared 32x32 multiplier does two passes for the generator step and
// one for weight times count on every dimension. Clear request: zeroes the total and
// empties every accumulator. Dump request: each result is read from memory, then presented,
// and held while the result side stalls. Throughput is one request at a time.
// Reset (synchronous, active high) zeroes the total and marks every accumulator empty at
// once through per-entry valid bits, so no clearing pass is needed.
module bbv_random_projection_counter_unit
   import bbvrpc_pkg::*;
#(
   parameter int NUM_DIMS = 16
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic [ADDR_W-1:0]      req_block_address,
   input  logic [COUNT_W-1:0]     req_instr_count,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DIM_INDEX_W-1:0] rsp_dim_index,
   output logic [ACC_W-1:0]       rsp_dim_value,
   output logic [ACC_W-1:0]       rsp_instr_total,
   output logic                   rsp_last
);

   localparam int IDX_W = $clog2(NUM_DIMS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIMS - 1);

   // Sequencer state and the dimension being worked on.
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   // Captured request count, running total and the four generator streams.
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [ACC_W-1:0]      total_ff, total_in;
   logic [LCG_W-1:0]      stream_ff [NUM_STREAMS];
   logic [LCG_W-1:0]      stream_in [NUM_STREAMS];

   // Product register behind the shared multiplier.
   logic [63:0]           prod_ff, prod_in;

   // Accumulator memory with one valid bit per entry; an empty entry reads as zero.
   logic [ACC_W-1:0]      acc_mem [NUM_DIMS];
   logic [NUM_DIMS-1:0]   valid_ff, valid_in;
   logic [ACC_W-1:0]      rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rd_en;
   logic                  wr_en;
   logic [ACC_W-1:0]      wr_data;
   logic [ACC_W-1:0]      acc_rd;

   // Shared multiplier.
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [63:0]           mul_p;

   // Generator step helpers for the stream selected by the low index bits.
   logic [LCG_W-1:0]      cur_stream;
   logic [31:0]           cur_lo;
   logic [15:0]           cur_hi;
   logic [15:0]           lo_times_hi;
   logic [15:0]           hi_part;

   logic [IDX_W+DIM_INDEX_W-1:0] idx_ext;

   assign cur_stream  = stream_ff[idx_ff[1:0]];
   assign cur_lo      = cur_stream[31:0];
   assign cur_hi      = cur_stream[47:32];
   assign lo_times_hi = cur_lo[15:0] * 16'(LCG_MUL_HI);

   // Only the low 16 bits of the cross terms survive modulo 2^48.
   assign hi_part     = mul_p[15:0] + lo_times_hi;

   assign mul_p       = mul_a * mul_b;
   assign acc_rd      = rd_valid_ff ? rd_data_ff : '0;
   assign wr_data     = acc_rd + prod_ff;

   // The result side is driven straight from registers that hold while stalled.
   assign idx_ext         = {{DIM_INDEX_W{1'b0}}, idx_ff};
   assign rsp_valid       = (state_ff == ST_DUMP_OUT);
   assign rsp_dim_index   = idx_ext[DIM_INDEX_W-1:0];
   assign rsp_dim_value   = acc_rd;
   assign rsp_instr_total = total_ff;
   assign rsp_last        = (idx_ff == LAST_IDX);
   assign req_stall       = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      for (int j = 0; j < NUM_STREAMS; j++) begin
         stream_ff[j] <= stream_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= acc_mem[idx_ff];
         rd_valid_ff <= valid_ff[idx_ff];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      prod_in  = prod_ff;
      valid_in = valid_ff;
      for (int j = 0; j < NUM_STREAMS; j++) begin
         stream_in[j] = stream_ff[j];
      end
      rd_en = 1'b0;
      wr_en = 1'b0;
      mul_a = cur_lo;
      mul_b = LCG_MUL_LO;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_COUNT: begin
                     // Seed each stream; only the low 32 address bits reach the
                     // 48-bit state after the 16-bit shift.
                     cnt_in   = req_instr_count;
                     total_in = total_ff + ACC_W'(req_instr_count);
                     for (int j = 0; j < NUM_STREAMS; j++) begin
                        stream_in[j] = {req_block_address[31:0] + 32'(j), SEED_LOW};
                     end
                     idx_in   = '0;
                     state_in = ST_CNT_LO;
                  end
                  CMD_CLEAR: begin
                     total_in = '0;
                     valid_in = '0;
                  end
                  CMD_DUMP: begin
                     idx_in   = '0;
                     state_in = ST_DUMP_RD;
                  end
                  default: begin
                     // The unused command code is dropped without effect.
                  end
               endcase
            end
         end

         ST_CNT_LO: begin
            // Low half of the generator product.
            mul_a    = cur_lo;
            mul_b    = LCG_MUL_LO;
            prod_in  = mul_p;
            state_in = ST_CNT_HI;
         end

         ST_CNT_HI: begin
            // Cross terms finish the step; the accumulator read starts here too.
            mul_a = {16'b0, cur_hi};
            mul_b = LCG_MUL_LO;
            stream_in[idx_ff[1:0]] = prod_ff[LCG_W-1:0] + {hi_part, 32'b0} + LCG_ADD;
            rd_en    = 1'b1;
            state_in = ST_CNT_W;
         end

         ST_CNT_W: begin
            // Weight is bits 16..31 of the freshly stepped stream.
            mul_a    = {16'b0, cur_stream[31:16]};
            mul_b    = cnt_ff;
            prod_in  = mul_p;
            state_in = ST_CNT_ACC;
         end

         ST_CNT_ACC: begin
            wr_en            = 1'b1;
            valid_in[idx_ff] = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_CNT_LO;
            end
         end

         ST_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = ST_DUMP_OUT;
         end

         ST_DUMP_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
